>>> rtl/core/tcw_pkg.sv
// Shared types and constants for the text console writer.
`default_nettype none

package tcw_pkg;

    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int OCOL_W  = 7;
    localparam int OROW_W  = 5;
    localparam int CELL_W  = 16;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;

    localparam logic [CELL_W-1:0] RESET_ATTR  = 16'h0700;
    localparam logic [CELL_W-1:0] RESET_BLANK = 16'h0720;

    // Register word index, taken from paddr[2].
    localparam logic REG_ATTR = 1'b0;

    typedef struct packed {
        logic accept;
        logic sweep_step;
        logic init_mode;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic scroll_req;
        logic clear_req;
        logic sweep_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/tcw_ctrl.sv
// Sequencing state machine for the text console writer.
`default_nettype none

module tcw_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire tcw_pkg::dp_status_t status,
    output tcw_pkg::dp_cmd_t        cmd
);
    import tcw_pkg::*;

    localparam logic [2:0] ST_INIT       = 3'd0;
    localparam logic [2:0] ST_INIT_FLUSH = 3'd1;
    localparam logic [2:0] ST_IDLE       = 3'd2;
    localparam logic [2:0] ST_SWEEP      = 3'd3;
    localparam logic [2:0] ST_FLUSH      = 3'd4;
    localparam logic [2:0] ST_RESULT     = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.sweep_step = 1'b1;
                cmd.init_mode  = 1'b1;
                if (status.sweep_last) state_next = ST_INIT_FLUSH;
            end
            ST_INIT_FLUSH: begin
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (status.scroll_req || status.clear_req) state_next = ST_SWEEP;
                    else state_next = ST_RESULT;
                end
            end
            ST_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last) state_next = ST_FLUSH;
            end
            ST_FLUSH: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/tcw_dp.sv
// Cell store, cursor, sweep counter and result register of the text console writer.
`default_nettype none

module tcw_dp #(
    parameter int COLUMNS = 80,
    parameter int LINES   = 25
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [tcw_pkg::CMD_W-1:0]    s_command,
    input  wire logic [tcw_pkg::CHAR_W-1:0]   s_char_code,
    input  wire logic [tcw_pkg::IDX_W-1:0]    s_cell_index,
    input  wire logic                         attr_we,
    input  wire logic [tcw_pkg::CELL_W-1:0]   attr_wdata,
    output logic      [tcw_pkg::CELL_W-1:0]   attr_q,
    input  wire tcw_pkg::dp_cmd_t             cmd,
    output tcw_pkg::dp_status_t               status,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [tcw_pkg::OCOL_W-1:0]   m_cursor_col,
    output logic      [tcw_pkg::OROW_W-1:0]   m_cursor_row,
    output logic      [tcw_pkg::CELL_W-1:0]   m_cell_data
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * LINES;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(LINES);

    logic [CELL_W-1:0] cell_mem [CELL_COUNT];

    logic [CELL_W-1:0] attr_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [AW-1:0]     sweep_cnt_reg;
    logic              copy_mode_reg;
    logic              wr_pend_reg;
    logic              wr_src_mem_reg;
    logic [AW-1:0]     wr_addr_reg;
    logic [CELL_W-1:0] wr_blank_reg;
    logic [CELL_W-1:0] rd_data_reg;
    logic              read_ok_reg;
    logic              m_valid_reg;
    logic [OCOL_W-1:0] m_col_reg;
    logic [OROW_W-1:0] m_row_reg;
    logic [CELL_W-1:0] m_data_reg;

    logic [COL_W:0]    col_ext;
    logic [ROW_W:0]    row_ext;
    logic [COL_W:0]    col_n;
    logic [ROW_W:0]    row_n;
    logic [COL_W:0]    tab_sum;
    logic              printable;
    logic              is_put;
    logic              scroll;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_next;
    logic [AW-1:0]     put_addr;
    logic [AW+IDX_W-1:0] idx_wide;
    logic              idx_ok;
    logic [AW:0]       cnt_ext;
    logic [AW:0]       src_ext;
    logic              copy_now;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] blank;
    logic [COL_W+OCOL_W-1:0] col_out;
    logic [ROW_W+OROW_W-1:0] row_out;

    assign blank   = attr_reg | {{(CELL_W-CHAR_W){1'b0}}, CH_SPACE};
    assign attr_q  = attr_reg;
    assign is_put  = (s_command == CMD_PUT);
    assign col_ext = {1'b0, col_reg};
    assign row_ext = {1'b0, row_reg};
    assign tab_sum = col_ext + (COL_W+1)'(8);
    assign printable = s_char_code inside {[CH_SPACE:CH_LAST]};

    always_comb begin
        col_n = col_ext;
        row_n = row_ext;
        case (s_char_code)
            CH_BS: begin
                if (col_reg != '0) begin
                    col_n = col_ext - (COL_W+1)'(1);
                end else if (row_reg != '0) begin
                    col_n = (COL_W+1)'(COLUMNS - 1);
                    row_n = row_ext - (ROW_W+1)'(1);
                end
            end
            CH_TAB: col_n = {tab_sum[COL_W:3], 3'b000};
            CH_CR:  col_n = '0;
            CH_LF: begin
                col_n = '0;
                row_n = row_ext + (ROW_W+1)'(1);
            end
            default: begin
                if (printable) col_n = col_ext + (COL_W+1)'(1);
            end
        endcase
        if (col_n >= (COL_W+1)'(COLUMNS)) begin
            col_n = '0;
            row_n = row_n + (ROW_W+1)'(1);
        end
        scroll = (row_n == (ROW_W+1)'(LINES));
        if (scroll) row_n = (ROW_W+1)'(LINES - 1);
    end

    assign col_next = col_n[COL_W-1:0];
    assign row_next = row_n[ROW_W-1:0];
    assign put_addr = AW'(AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg));

    assign idx_wide = {{AW{1'b0}}, s_cell_index};
    assign idx_ok   = idx_wide < (AW+IDX_W)'(CELL_COUNT);

    assign cnt_ext  = {1'b0, sweep_cnt_reg};
    assign src_ext  = cnt_ext + (AW+1)'(COLUMNS);
    assign copy_now = copy_mode_reg && !cmd.init_mode
                      && (cnt_ext < (AW+1)'(CELL_COUNT - COLUMNS));

    assign status.scroll_req = is_put && scroll;
    assign status.clear_req  = (s_command == CMD_CLEAR);
    assign status.sweep_last = (sweep_cnt_reg == AW'(CELL_COUNT - 1));
    assign status.out_free   = !m_valid_reg || m_ready;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = wr_src_mem_reg ? rd_data_reg : wr_blank_reg;
        if (wr_pend_reg) begin
            mem_we = 1'b1;
        end else if (cmd.accept && is_put && printable) begin
            mem_we    = 1'b1;
            mem_waddr = put_addr;
            mem_wdata = attr_reg | {{(CELL_W-CHAR_W){1'b0}}, s_char_code};
        end
        mem_re    = 1'b0;
        mem_raddr = idx_wide[AW-1:0];
        if (cmd.sweep_step) begin
            mem_re    = copy_now;
            mem_raddr = src_ext[AW-1:0];
        end else if (cmd.accept && (s_command == CMD_READ) && idx_ok) begin
            mem_re = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) cell_mem[mem_waddr] <= mem_wdata;
        if (mem_re) rd_data_reg <= cell_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg      <= RESET_ATTR;
            col_reg       <= '0;
            row_reg       <= '0;
            sweep_cnt_reg <= '0;
            copy_mode_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
            read_ok_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (attr_we) attr_reg <= attr_wdata;
            wr_pend_reg <= cmd.sweep_step;
            if (cmd.accept) begin
                read_ok_reg   <= (s_command == CMD_READ) && idx_ok;
                copy_mode_reg <= status.scroll_req;
                if (is_put) begin
                    col_reg <= col_next;
                    row_reg <= row_next;
                end else if (status.clear_req) begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
            end
            if (cmd.sweep_step) begin
                if (status.sweep_last) sweep_cnt_reg <= '0;
                else sweep_cnt_reg <= sweep_cnt_reg + AW'(1);
            end
            if (cmd.out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sweep_step) begin
            wr_addr_reg    <= sweep_cnt_reg;
            wr_src_mem_reg <= copy_now;
            wr_blank_reg   <= cmd.init_mode ? RESET_BLANK : blank;
        end
    end

    assign col_out = {{OCOL_W{1'b0}}, col_reg};
    assign row_out = {{OROW_W{1'b0}}, row_reg};

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_col_reg  <= col_out[OCOL_W-1:0];
            m_row_reg  <= row_out[OROW_W-1:0];
            m_data_reg <= read_ok_reg ? rd_data_reg : '0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cursor_col = m_col_reg;
    assign m_cursor_row = m_row_reg;
    assign m_cell_data  = m_data_reg;

    a_no_port_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.accept && wr_pend_reg))
        else $error("put write collides with sweep write");

    a_sweep_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sweep_step && status.sweep_last |=> sweep_cnt_reg == '0)
        else $error("sweep counter did not return to zero");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_ext < (COL_W+1)'(COLUMNS)) && (row_ext < (ROW_W+1)'(LINES)))
        else $error("cursor outside the screen");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

endmodule

`default_nettype wire

>>> rtl/core/text_console_writer_unit.sv
// Top level of the text console writer: APB register, controller and datapath.
// Put and read items: the controller moves to its result state and loads the result register
// once it is free; s_ready stays low until then, so no new item is taken before that load.
// Clear, and a put that scrolls: the cell RAM is swept one cell per cycle by the single RAM write port.
// Reset (synchronous, active low) homes the cursor, loads attribute 0x0700 and
// blanks the RAM in a sweep pass; s_ready stays low until it ends.
`default_nettype none

module text_console_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int LINES   = 25
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [tcw_pkg::CMD_W-1:0]    s_command,
    input  wire logic [tcw_pkg::CHAR_W-1:0]   s_char_code,
    input  wire logic [tcw_pkg::IDX_W-1:0]    s_cell_index,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [tcw_pkg::OCOL_W-1:0]   m_cursor_col,
    output logic      [tcw_pkg::OROW_W-1:0]   m_cursor_row,
    output logic      [tcw_pkg::CELL_W-1:0]   m_cell_data,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tcw_pkg::APB_AW-1:0]   paddr,
    input  wire logic [tcw_pkg::APB_DW-1:0]   pwdata,
    output logic      [tcw_pkg::APB_DW-1:0]   prdata,
    output logic                              pready
);
    import tcw_pkg::*;

    dp_cmd_t           cmd;
    dp_status_t        status;
    logic              attr_we;
    logic [CELL_W-1:0] attr_q;

    assign pready  = 1'b1;
    assign attr_we = psel && penable && pwrite && (paddr[2] == REG_ATTR);
    assign prdata  = (paddr[2] == REG_ATTR) ? {{(APB_DW-CELL_W){1'b0}}, attr_q} : '0;

    tcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tcw_dp #(
        .COLUMNS (COLUMNS),
        .LINES   (LINES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_command    (s_command),
        .s_char_code  (s_char_code),
        .s_cell_index (s_cell_index),
        .attr_we      (attr_we),
        .attr_wdata   (pwdata[CELL_W-1:0]),
        .attr_q       (attr_q),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cursor_col (m_cursor_col),
        .m_cursor_row (m_cursor_row),
        .m_cell_data  (m_cell_data)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the text console writer: command beats checked against a cell-store model.
`timescale 1ns / 1ps

module tb_top;
    import tcw_pkg::*;

    localparam int COLUMNS     = 80;
    localparam int LINES       = 25;
    localparam int CELLS       = COLUMNS * LINES;
    localparam int IDLE_PCT    = 13;
    localparam int DRAIN_PAD   = 8;
    localparam int HOLD_CYCLES = 600;
    localparam int QUIET_LIMIT = 20000;

    localparam logic [CMD_W-1:0]  CMD_NONE  = 2'd3;
    localparam logic [APB_AW-1:0] ADDR_ATTR = {REG_ATTR, 2'b00};

    typedef struct packed {
        logic [OCOL_W-1:0] col;
        logic [OROW_W-1:0] row;
        logic [CELL_W-1:0] data;
    } console_result_t;

    class console_scoreboard;
        logic [CELL_W-1:0] cells [CELLS];
        logic [CELL_W-1:0] attr;
        int col;
        int row;
        console_result_t awaited[$];
        int errors;
        int checked;
        int n_put;
        int n_read;
        int n_clear;
        int n_scroll;

        function new();
            attr     = RESET_ATTR;
            errors   = 0;
            checked  = 0;
            n_put    = 0;
            n_read   = 0;
            n_clear  = 0;
            n_scroll = 0;
            blank_all();
        endfunction

        function void blank_all();
            for (int i = 0; i < CELLS; i++) cells[i] = {8'h00, CH_SPACE} | attr;
            col = 0;
            row = 0;
        endfunction

        function void mismatch(string what);
            errors++;
            if (errors <= 10) $display("MISMATCH %s", what);
        endfunction

        function void note_input(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                 logic [IDX_W-1:0] idx);
            console_result_t r;
            r.data = '0;
            case (cmd)
                CMD_PUT: begin
                    n_put++;
                    if (ch == CH_BS) begin
                        if (col > 0) begin
                            col--;
                        end else if (row > 0) begin
                            col = COLUMNS - 1;
                            row--;
                        end
                    end else if (ch == CH_TAB) begin
                        col = (col + 8) & ~7;
                    end else if (ch == CH_CR) begin
                        col = 0;
                    end else if (ch == CH_LF) begin
                        col = 0;
                        row++;
                    end else if (ch >= CH_SPACE && ch <= CH_LAST) begin
                        cells[row * COLUMNS + col] = {8'h00, ch} | attr;
                        col++;
                    end
                    if (col >= COLUMNS) begin
                        col = 0;
                        row++;
                    end
                    if (row >= LINES) begin
                        for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
                        for (int i = CELLS - COLUMNS; i < CELLS; i++)
                            cells[i] = {8'h00, CH_SPACE} | attr;
                        row = LINES - 1;
                        n_scroll++;
                    end
                end
                CMD_READ: begin
                    n_read++;
                    if (idx < CELLS) r.data = cells[idx];
                end
                CMD_CLEAR: begin
                    n_clear++;
                    blank_all();
                end
                default: ;
            endcase
            r.col = OCOL_W'(col);
            r.row = OROW_W'(row);
            awaited.push_back(r);
        endfunction

        function void check_result(logic [OCOL_W-1:0] c, logic [OROW_W-1:0] r,
                                   logic [CELL_W-1:0] d);
            console_result_t want;
            if (awaited.size() == 0) begin
                mismatch($sformatf("unexpected beat col=%0d row=%0d data=%h", c, r, d));
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (c !== want.col || r !== want.row || d !== want.data)
                mismatch($sformatf("result %0d: col/row/data expected %0d/%0d/%h got %0d/%0d/%h",
                                   checked, want.col, want.row, want.data, c, r, d));
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [CMD_W-1:0]    s_command;
    logic [CHAR_W-1:0]   s_char_code;
    logic [IDX_W-1:0]    s_cell_index;
    logic                m_valid;
    logic                m_ready;
    logic [OCOL_W-1:0]   m_cursor_col;
    logic [OROW_W-1:0]   m_cursor_row;
    logic [CELL_W-1:0]   m_cell_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    console_scoreboard scb = new();
    logic calm     = 1'b0;
    logic hold_req = 1'b0;
    int   n_items  = 0;
    int   n_cfg    = 0;

    text_console_writer_unit #(
        .COLUMNS(COLUMNS),
        .LINES  (LINES)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_char_code (s_char_code),
        .s_cell_index(s_cell_index),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cursor_col(m_cursor_col),
        .m_cursor_row(m_cursor_row),
        .m_cell_data (m_cell_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int idle_gap();
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(0, 99) < IDLE_PCT) gap++;
        return gap;
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                             input logic [IDX_W-1:0] idx);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_char_code  <= ch;
        s_cell_index <= idx;
        do @(posedge aclk); while (!s_ready);
        scb.note_input(cmd, ch, idx);
        n_items++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (scb.awaited.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAD) @(posedge aclk);
    endtask

    task automatic set_attribute(input logic [CELL_W-1:0] value);
        logic [APB_DW-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ATTR;
        pwdata  <= APB_DW'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        scb.attr = value;
        n_cfg++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[CELL_W-1:0] !== value)
            scb.mismatch($sformatf("attribute readback expected %h got %h", value, rd));
    endtask

    // Mostly text with control bytes; reads lean toward rows already written.
    task automatic run_random(input int count, input int hold_at, input int calm_from,
                              input int calm_to);
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        int pick;
        for (int k = 0; k < count; k++) begin
            calm = (k >= calm_from && k < calm_to);
            if (k == hold_at) hold_req = 1'b1;
            pick = $urandom_range(0, 999);
            cmd  = CMD_PUT;
            ch   = CHAR_W'($urandom_range(CH_SPACE, CH_LAST));
            idx  = IDX_W'($urandom);
            if (pick < 5) begin
                cmd = CMD_CLEAR;
            end else if (pick < 15) begin
                cmd = CMD_NONE;
            end else if (pick < 90) begin
                cmd = CMD_READ;
                idx = IDX_W'($urandom_range(0, scb.row) * COLUMNS
                             + $urandom_range(0, COLUMNS - 1));
            end else if (pick < 160) begin
                cmd = CMD_READ;
            end else if (pick < 210) begin
                ch = CHAR_W'($urandom);
            end else if (pick < 250) begin
                ch = CH_LF;
            end else if (pick < 290) begin
                ch = CH_TAB;
            end else if (pick < 310) begin
                ch = CH_CR;
            end else if (pick < 350) begin
                ch = CH_BS;
            end
            send_item(cmd, ch, idx);
        end
        calm = 1'b0;
    endtask

    // Result side: checks beats and applies random and long hold-offs.
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) scb.check_result(m_cursor_col, m_cursor_row, m_cell_data);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("Watchdog: no beat for %0d cycles", QUIET_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        s_valid      = 1'b0;
        s_command    = CMD_PUT;
        s_char_code  = '0;
        s_cell_index = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        aresetn      = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(CMD_READ, 8'h00, 11'd0);
        send_item(CMD_READ, 8'hFF, 11'(CELLS - 1));
        send_item(CMD_READ, 8'h00, 11'(CELLS));
        send_item(CMD_READ, 8'h00, '1);
        send_item(CMD_PUT, CH_BS, '0);
        send_item(CMD_PUT, "A", '0);
        send_item(CMD_PUT, CH_SPACE, '0);
        send_item(CMD_PUT, CH_LAST, '0);
        send_item(CMD_PUT, 8'h1F, '0);
        send_item(CMD_PUT, 8'h80, '0);
        send_item(CMD_PUT, 8'hFF, '0);
        send_item(CMD_PUT, 8'h00, '0);
        send_item(CMD_PUT, CH_TAB, '0);
        send_item(CMD_PUT, CH_CR, '0);
        send_item(CMD_PUT, CH_LF, '0);
        send_item(CMD_PUT, CH_BS, '0);
        send_item(CMD_READ, '0, 11'd0);
        send_item(CMD_READ, '0, 11'd3);
        send_item(CMD_NONE, 8'hA5, 11'h5A5);
        send_item(CMD_CLEAR, '0, '0);
        send_item(CMD_READ, '0, 11'd0);
        drain();

        set_attribute(16'h0000);
        run_random(500, -1, -1, -1);
        drain();
        set_attribute(16'hFFFF);
        run_random(250, -1, -1, -1);
        drain();
        set_attribute(CELL_W'($urandom));
        run_random(600, 150, 300, 500);
        drain();
        set_attribute(CELL_W'($urandom));
        run_random(650, -1, 0, 200);
        drain();

        $display("Sent %0d beats: %0d puts, %0d reads, %0d clears, %0d scrolls",
                 n_items, scb.n_put, scb.n_read, scb.n_clear, scb.n_scroll);
        $display("Checked %0d results over %0d attribute settings, %0d mismatches",
                 scb.checked, n_cfg, scb.errors);
        if (scb.errors == 0 && scb.awaited.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
